// File: sv/udpgen_pkg.sv
// ----------------------------------------------------------------------------
// udpgen_pkg
// Shared types and constants for the UDP/IPv4 frame generator.
// ----------------------------------------------------------------------------
package udpgen_pkg;

    localparam int SLOT_BYTES = 2048;
    localparam int HDR_BYTES  = 42;

    // payload length limit: what fits in the slot and in 11 bits
    localparam logic [10:0] LEN_CAP =
        11'((SLOT_BYTES - HDR_BYTES) < 2047 ? (SLOT_BYTES - HDR_BYTES) : 2047);

    localparam logic [5:0] LAST_OFF = 6'(HDR_BYTES);

    // configuration register indexes
    localparam logic REG_MIN_PAYLOAD = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    localparam logic [10:0] MIN_PAYLOAD_RST = 11'd18;
    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1472;

    localparam logic [10:0] PORT_MOD   = 11'd1000;
    localparam logic [15:0] SPORT_BASE = 16'd1024;
    localparam logic [15:0] DPORT      = 16'd8080;
    localparam logic [15:0] ETHERTYPE  = 16'h0800;
    localparam logic [15:0] IP_LEN_OFS = 16'd28;
    localparam logic [15:0] UDP_LEN_OFS = 16'd8;
    localparam logic [31:0] SRC_IP_BASE = 32'h0A00_0001;
    localparam logic [31:0] DST_IP      = 32'hC0A8_0101;
    localparam logic [7:0]  IP_VER_IHL  = 8'h45;
    localparam logic [7:0]  IP_TTL      = 8'd64;
    localparam logic [7:0]  IP_PROTO    = 8'd17;
    localparam logic [7:0]  MAC_LOCAL   = 8'h02;
    localparam logic [15:0] CSUM_MASK   = 16'hFFFF;

    // fixed header words of the checksum: version/tos, ttl/proto,
    // source IP high word, base of source IP low word, destination IP
    localparam logic [18:0] CSUM_FIXED =
        19'({IP_VER_IHL, 8'h00}) + 19'({IP_TTL, IP_PROTO})
        + 19'(SRC_IP_BASE[31:16]) + 19'(SRC_IP_BASE[15:0])
        + 19'(DST_IP[31:16]) + 19'(DST_IP[15:0]);

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_LEN,
        FS_SUM
    } t_front_state;

    // one frame as handed from the front end to the byte sequencer
    typedef struct packed {
        logic [31:0] idx;
        logic [10:0] len;
        logic [15:0] csum;
        logic [9:0]  port_rem;
    } t_desc;

endpackage

// File: sv/udpgen_front.sv
// ----------------------------------------------------------------------------
// udpgen_front
// Takes a packet index, works out the length remainder bit-serially and the
// source port remainder by folding, and builds the frame descriptor (length,
// header checksum, source port remainder).
// ----------------------------------------------------------------------------
module udpgen_front
    import udpgen_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_packet_index,
    input  logic [10:0] i_min_payload,
    input  logic [10:0] i_max_payload,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_desc       o_q_desc
);

    t_front_state r_state, n_state;
    logic [31:0]  r_idx, r_shift;
    logic [4:0]   r_cnt;
    logic [10:0]  r_lo;
    logic [11:0]  r_div;
    logic [11:0]  r_rem;
    logic [17:0]  r_pm;
    logic [9:0]   r_rem1k;
    logic [10:0]  r_len;

    logic         accept;
    logic [10:0]  hi_eff;
    logic [12:0]  trial;
    logic [12:0]  trial_red;
    logic [17:0]  pm_bytes;
    logic [17:0]  pm_fold;
    logic [9:0]   pm_red;
    logic [11:0]  len_sum;
    logic [15:0]  ip_len;
    logic [18:0]  csum_raw;
    logic [16:0]  fold1;
    logic [15:0]  fold2;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (accept) n_state = FS_DIV;
            FS_DIV:  if (r_cnt == 5'd31) n_state = FS_LEN;
            FS_LEN:  n_state = FS_SUM;
            FS_SUM: begin
                if (!i_q_full) n_state = accept ? FS_DIV : FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_full   = 1'b1;
        o_q_push = 1'b0;
        unique case (r_state)
            FS_IDLE: o_full = 1'b0;
            FS_SUM: begin
                o_full   = i_q_full;
                o_q_push = !i_q_full;
            end
            default: ;
        endcase
    end

    assign accept = i_push && !o_full;
    assign hi_eff = (i_max_payload < i_min_payload) ? i_min_payload : i_max_payload;

    // one restoring step per cycle for the length remainder
    always_comb begin
        trial     = {r_rem, r_shift[31]};
        trial_red = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
    end

    // port remainder: bytes weighted by 256^k mod 1000, then folded
    // twice using 1024 = 24 mod 1000, then one trim
    always_comb begin
        pm_bytes = {10'd0, r_idx[7:0]} + {2'd0, r_idx[15:8], 8'd0}
                   + {10'd0, r_idx[23:16]} * 18'd536
                   + {10'd0, r_idx[31:24]} * 18'd216;
        pm_fold  = {8'd0, r_pm[9:0]} + {10'd0, r_pm[17:10]} * 18'd24;
        pm_red   = (r_pm >= {7'd0, PORT_MOD}) ? 10'(r_pm - {7'd0, PORT_MOD})
                                               : r_pm[9:0];
    end

    assign len_sum = {1'b0, r_lo} + r_rem;

    // ones-complement header sum, folded twice
    always_comb begin
        ip_len   = IP_LEN_OFS + {5'd0, r_len};
        csum_raw = CSUM_FIXED + {3'd0, ip_len} + {3'd0, r_idx[15:0]}
                   + {11'd0, r_idx[7:0]};
        fold1    = {1'b0, csum_raw[15:0]} + {14'd0, csum_raw[18:16]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};
    end

    assign o_q_desc.idx      = r_idx;
    assign o_q_desc.len      = r_len;
    assign o_q_desc.csum     = ~fold2 & CSUM_MASK;
    assign o_q_desc.port_rem = r_rem1k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= i_packet_index;
            r_shift <= i_packet_index;
            r_cnt   <= 5'd0;
            r_lo    <= i_min_payload;
            r_div   <= {1'b0, hi_eff} - {1'b0, i_min_payload} + 12'd1;
            r_rem   <= 12'd0;
        end else if (r_state == FS_DIV) begin
            r_shift <= {r_shift[30:0], 1'b0};
            r_cnt   <= r_cnt + 5'd1;
            r_rem   <= trial_red[11:0];
            if (r_cnt == 5'd0) begin
                r_pm <= pm_bytes;
            end else if (r_cnt < 5'd3) begin
                r_pm <= pm_fold;
            end else if (r_cnt == 5'd3) begin
                r_rem1k <= pm_red;
            end
        end
        if (r_state == FS_LEN) begin
            r_len <= (len_sum > {1'b0, LEN_CAP}) ? LEN_CAP : len_sum[10:0];
        end
    end

endmodule

// File: sv/udpgen_queue.sv
// ----------------------------------------------------------------------------
// udpgen_queue
// Two-deep descriptor queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module udpgen_queue
    import udpgen_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_avail,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: sv/udpgen_back.sv
// ----------------------------------------------------------------------------
// udpgen_back
// Byte sequencer: walks a descriptor through the 43 frame offsets into a
// registered output word.
// ----------------------------------------------------------------------------
module udpgen_back
    import udpgen_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_avail,
    input  t_desc       i_q_desc,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_data_byte,
    output logic [5:0]  o_byte_offset,
    output logic        o_last_byte,
    output logic [10:0] o_payload_length
);

    logic        r_busy;
    logic [5:0]  r_off;
    t_desc       r_d;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic [5:0]  r_ofs_out;
    logic        r_last;
    logic [10:0] r_len_out;

    logic        emit, at_last, load;
    logic [15:0] ip_len, udp_len, sport;
    logic [8:0]  sip_lo;
    logic [7:0]  cur_byte;

    assign emit    = r_busy && (!r_ov || i_pop);
    assign at_last = (r_off == LAST_OFF);
    assign load    = i_q_avail && (!r_busy || (emit && at_last));
    assign o_q_pop = load;

    always_comb begin
        ip_len  = IP_LEN_OFS + {5'd0, r_d.len};
        udp_len = UDP_LEN_OFS + {5'd0, r_d.len};
        sport   = SPORT_BASE + {6'd0, r_d.port_rem};
        // low byte of the source IP can carry into the byte above it
        sip_lo  = {1'b0, r_d.idx[7:0]} + {1'b0, SRC_IP_BASE[7:0]};
    end

    always_comb begin
        unique case (r_off)
            6'd0, 6'd6: cur_byte = MAC_LOCAL;
            6'd5:       cur_byte = 8'h01;
            6'd11:      cur_byte = 8'h02;
            6'd12:      cur_byte = ETHERTYPE[15:8];
            6'd13:      cur_byte = ETHERTYPE[7:0];
            6'd14:      cur_byte = IP_VER_IHL;
            6'd16:      cur_byte = ip_len[15:8];
            6'd17:      cur_byte = ip_len[7:0];
            6'd18:      cur_byte = r_d.idx[15:8];
            6'd19:      cur_byte = r_d.idx[7:0];
            6'd22:      cur_byte = IP_TTL;
            6'd23:      cur_byte = IP_PROTO;
            6'd24:      cur_byte = r_d.csum[15:8];
            6'd25:      cur_byte = r_d.csum[7:0];
            6'd26:      cur_byte = SRC_IP_BASE[31:24];
            6'd27:      cur_byte = SRC_IP_BASE[23:16];
            6'd28:      cur_byte = SRC_IP_BASE[15:8] + {7'd0, sip_lo[8]};
            6'd29:      cur_byte = sip_lo[7:0];
            6'd30:      cur_byte = DST_IP[31:24];
            6'd31:      cur_byte = DST_IP[23:16];
            6'd32:      cur_byte = DST_IP[15:8];
            6'd33:      cur_byte = DST_IP[7:0];
            6'd34:      cur_byte = sport[15:8];
            6'd35:      cur_byte = sport[7:0];
            6'd36:      cur_byte = DPORT[15:8];
            6'd37:      cur_byte = DPORT[7:0];
            6'd38:      cur_byte = udp_len[15:8];
            6'd39:      cur_byte = udp_len[7:0];
            6'd42:      cur_byte = r_d.idx[7:0];
            default:    cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && at_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_d   <= i_q_desc;
            r_off <= 6'd0;
        end else if (emit) begin
            r_off <= r_off + 6'd1;
        end
        if (emit) begin
            r_byte    <= cur_byte;
            r_ofs_out <= r_off;
            r_last    <= at_last;
            r_len_out <= r_d.len;
        end
    end

    assign o_empty          = !r_ov;
    assign o_data_byte      = r_byte;
    assign o_byte_offset    = r_ofs_out;
    assign o_last_byte      = r_last;
    assign o_payload_length = r_len_out;

endmodule

// File: sv/udp_ipv4_frame_generator.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_generator
// Emits the 42-byte Ethernet/IPv4/UDP header and one pattern byte per index.
// ----------------------------------------------------------------------------
// Path: an accepted index runs through the front end's 32-step serial remainder
//   unit, its length and sum states, the queue and the output word to the ports.
// Throughput: one byte per cycle while the reader keeps popping, set by the byte
//   sequencer; the front end runs ahead, buffered by the descriptor queue.
// Reset: synchronous; registers return to min 18 / max 1472, queue and
//   output word are emptied.
module udp_ipv4_frame_generator
    import udpgen_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_packet_index,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_data_byte,
    output logic [5:0]  o_byte_offset,
    output logic        o_last_byte,
    output logic [10:0] o_payload_length
);

    logic [10:0] r_min_payload, r_max_payload;
    logic        q_push, q_full, q_avail, q_pop;
    t_desc       q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_payload <= MIN_PAYLOAD_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                REG_MIN_PAYLOAD: r_min_payload <= i_cfg_data;
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    udpgen_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_packet_index (i_packet_index),
        .i_min_payload  (r_min_payload),
        .i_max_payload  (r_max_payload),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_desc       (q_in)
    );

    udpgen_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_desc  (q_out)
    );

    udpgen_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_avail        (q_avail),
        .i_q_desc         (q_out),
        .o_q_pop          (q_pop),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_data_byte      (o_data_byte),
        .o_byte_offset    (o_byte_offset),
        .o_last_byte      (o_last_byte),
        .o_payload_length (o_payload_length)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("descriptor queue written while full");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_byte == (o_byte_offset == LAST_OFF)))
        else $error("last flag off the final offset");

    a_len_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_payload_length <= LEN_CAP))
        else $error("payload length above slot limit");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_byte) |=> (o_empty || o_byte_offset == 6'd0))
        else $error("frame did not restart at offset zero");

endmodule
